/* rtl/core/fwips_pkg.sv */
// Shared types and constants of the four-wheel incremental PI speed block.
package fwips_pkg;

   localparam int WHEELS = 4;

   // Field widths
   localparam int VEL_W   = 16;
   localparam int COUNT_W = 16;
   localparam int GAIN_W  = 16;
   localparam int DUTY_W  = 13;
   localparam int SPEED_W = 18;   // exact sum of three 16-bit commands
   localparam int ERR_W   = 18;
   localparam int STEP_W  = 21;   // holds +-2200*256
   localparam int ACC_W   = 22;   // holds +-5000*256

   // Q8.8 speed to encoder count scale, 237.17
   localparam logic [16:0] SPEED_SCALE = 17'd60717;

   localparam int STEP_LIMIT = 2200 * 256;
   localparam int OUT_LIMIT  = 5000 * 256;

   // Register map (index, byte address is 4 * index)
   localparam logic [2:0] REG_KP_ONE   = 3'd0;
   localparam logic [2:0] REG_KP_TWO   = 3'd1;
   localparam logic [2:0] REG_KP_THREE = 3'd2;
   localparam logic [2:0] REG_KP_FOUR  = 3'd3;
   localparam logic [2:0] REG_KI_ONE   = 3'd4;
   localparam logic [2:0] REG_KI_TWO   = 3'd5;
   localparam logic [2:0] REG_KI_THREE = 3'd6;
   localparam logic [2:0] REG_KI_FOUR  = 3'd7;

   // Gain reset values
   localparam logic [GAIN_W-1:0] KP_ONE_RST   = 16'd9984;
   localparam logic [GAIN_W-1:0] KP_TWO_RST   = 16'd8704;
   localparam logic [GAIN_W-1:0] KP_THREE_RST = 16'd8704;
   localparam logic [GAIN_W-1:0] KP_FOUR_RST  = 16'd8192;
   localparam logic [GAIN_W-1:0] KI_ONE_RST   = 16'd640;
   localparam logic [GAIN_W-1:0] KI_TWO_RST   = 16'd691;
   localparam logic [GAIN_W-1:0] KI_THREE_RST = 16'd486;
   localparam logic [GAIN_W-1:0] KI_FOUR_RST  = 16'd563;

   typedef logic signed [SPEED_W-1:0] speed_type;
   typedef logic signed [COUNT_W-1:0] count_type;
   typedef logic        [GAIN_W-1:0]  gain_type;
   typedef logic        [DUTY_W-1:0]  duty_type;

   // Per-phase load strobes handed to every lane
   typedef struct packed {
      logic ld_prod;    // speed * scale
      logic ld_err;     // target count and error
      logic ld_mul;     // gain products
      logic ld_step;    // summed and clamped step
      logic commit;     // accumulator and previous error update
   } lane_ctrl_type;

endpackage

/* rtl/core/fwips_mix.sv */
// Mecanum mixing of the body velocity command into four wheel speeds.
module fwips_mix (
   input  logic                         clock,
   input  logic                         load,
   input  logic signed [15:0]           vel_x,
   input  logic signed [15:0]           vel_y,
   input  logic signed [15:0]           vel_rot,
   output fwips_pkg::speed_type         speed_one,
   output fwips_pkg::speed_type         speed_two,
   output fwips_pkg::speed_type         speed_three,
   output fwips_pkg::speed_type         speed_four
);
   import fwips_pkg::*;

   speed_type x_w, y_w, r_w;
   speed_type one_in, two_in, three_in, four_in;
   speed_type one_ff, two_ff, three_ff, four_ff;

   assign x_w = SPEED_W'(vel_x);
   assign y_w = SPEED_W'(vel_y);
   assign r_w = SPEED_W'(vel_rot);

   assign one_in   = -x_w + y_w + r_w;
   assign two_in   =  x_w + y_w + r_w;
   assign three_in = -x_w - y_w + r_w;
   assign four_in  =  x_w - y_w + r_w;

   always_ff @(posedge clock) begin
      if (load) begin
         one_ff   <= one_in;
         two_ff   <= two_in;
         three_ff <= three_in;
         four_ff  <= four_in;
      end
   end

   assign speed_one   = one_ff;
   assign speed_two   = two_ff;
   assign speed_three = three_ff;
   assign speed_four  = four_ff;

endmodule

/* rtl/core/fwips_lane.sv */
// One wheel's speed target, incremental PI step, accumulator and duty split.
module fwips_lane (
   input  logic                         clock,
   input  logic                         reset,
   input  fwips_pkg::lane_ctrl_type     ctrl,
   input  fwips_pkg::speed_type         speed,
   input  fwips_pkg::count_type         count,
   input  fwips_pkg::gain_type          kp,
   input  fwips_pkg::gain_type          ki,
   output fwips_pkg::duty_type          fwd_duty,
   output fwips_pkg::duty_type          rev_duty
);
   import fwips_pkg::*;

   localparam logic signed [36:0] STEP_HI = 37'(STEP_LIMIT);
   localparam logic signed [36:0] STEP_LO = -STEP_HI;
   localparam logic signed [22:0] OUT_HI  = 23'(OUT_LIMIT);
   localparam logic signed [22:0] OUT_LO  = -OUT_HI;

   logic signed [34:0]       prod_in, prod_ff;
   logic                     neg_w;
   logic        [34:0]       mag_w;
   logic signed [19:0]       tgt_w;
   logic signed [19:0]       err_w;
   logic signed [ERR_W-1:0]  err_in, err_ff;
   logic signed [18:0]       diff_w;
   logic signed [35:0]       pprod_in, pprod_ff;
   logic signed [34:0]       iprod_in, iprod_ff;
   logic signed [36:0]       sum_w;
   logic signed [STEP_W-1:0] step_in, step_ff;
   logic signed [22:0]       asum_w;
   logic signed [ACC_W-1:0]  acc_in, acc_ff;
   logic signed [ERR_W-1:0]  prev_ff;
   logic        [ACC_W-1:0]  amag_w;

   // Target count, truncated toward zero
   assign prod_in = 35'(speed) * $signed({1'b0, SPEED_SCALE});
   assign neg_w   = prod_ff[34];
   assign mag_w   = neg_w ? 35'(-prod_ff) : prod_ff;
   assign tgt_w   = neg_w ? -$signed({1'b0, mag_w[34:16]}) : $signed({1'b0, mag_w[34:16]});
   assign err_w   = tgt_w - 20'(count);
   assign err_in  = err_w[ERR_W-1:0];

   // Gain products
   assign diff_w   = 19'(err_ff) - 19'(prev_ff);
   assign pprod_in = 36'(diff_w) * $signed({1'b0, kp});
   assign iprod_in = 35'(err_ff) * $signed({1'b0, ki});

   // Step clamp
   assign sum_w = 37'(pprod_ff) + 37'(iprod_ff);
   always_comb begin
      if (sum_w > STEP_HI) begin
         step_in = STEP_HI[STEP_W-1:0];
      end else if (sum_w < STEP_LO) begin
         step_in = STEP_LO[STEP_W-1:0];
      end else begin
         step_in = sum_w[STEP_W-1:0];
      end
   end

   // Accumulator clamp
   assign asum_w = 23'(acc_ff) + 23'(step_ff);
   always_comb begin
      if (asum_w > OUT_HI) begin
         acc_in = OUT_HI[ACC_W-1:0];
      end else if (asum_w < OUT_LO) begin
         acc_in = OUT_LO[ACC_W-1:0];
      end else begin
         acc_in = asum_w[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_prod) prod_ff <= prod_in;
      if (ctrl.ld_err)  err_ff  <= err_in;
      if (ctrl.ld_mul) begin
         pprod_ff <= pprod_in;
         iprod_ff <= iprod_in;
      end
      if (ctrl.ld_step) step_ff <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         prev_ff <= '0;
      end else if (ctrl.commit) begin
         acc_ff  <= acc_in;
         prev_ff <= err_ff;
      end
   end

   // Duty split of the new accumulator; fractions toward zero drop out
   assign amag_w   = acc_in[ACC_W-1] ? ACC_W'(-acc_in) : acc_in;
   assign fwd_duty = acc_in[ACC_W-1] ? '0 : amag_w[DUTY_W+7:8];
   assign rev_duty = acc_in[ACC_W-1] ? amag_w[DUTY_W+7:8] : '0;

endmodule

/* rtl/core/four_wheel_incremental_pi_speed_top.sv */
// Top level of the four-wheel incremental PI speed controller.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+------------------------------------------
//  req_    | in  | req_tvalid / req_tready | 112 b: vel_x vel_y vel_rot count_one..four
//  rsp_    | out | rsp_tvalid / rsp_tready | 104 b: fwd/rev duty of wheels one..four
//  csr_    | in  | APB, pready tied high   | 8 x 16 b gains: kp one..four, ki one..four
//
// Flow: one transfer in, then the lane chain runs and the result is registered at the commit;
// the next request is taken the cycle after the commit, so no new request is taken before the last one commits.
// The per-lane chain runs: scale multiply, error, gain multiplies,
// step clamp, accumulator commit. All four wheel lanes run this chain side by side.
// Reset (synchronous, active high) clears the accumulators, previous errors,
// sequencer and output valid, and loads the gain reset values.
// Stalls: with a result still waiting on rsp_, the sequencer holds at the commit
// phase; the lane state is only updated once the output register is free.
module four_wheel_incremental_pi_speed_top (
   input  logic          clock,
   input  logic          reset,
   // request stream
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [111:0]  req_tdata,   // vel_x, vel_y, vel_rot, count_one..count_four
   // result stream
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [103:0]  rsp_tdata,   // fwd_one, rev_one, fwd_two, rev_two, .. rev_four
   // register port
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [4:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);
   import fwips_pkg::*;

   // Sequencer phases
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_PROD   = 3'd1;
   localparam logic [2:0] PH_ERR    = 3'd2;
   localparam logic [2:0] PH_MUL    = 3'd3;
   localparam logic [2:0] PH_STEP   = 3'd4;
   localparam logic [2:0] PH_COMMIT = 3'd5;

   logic [2:0]     phase_ff, phase_in;
   logic           req_xfer;
   logic           commit;
   lane_ctrl_type  ctrl;

   gain_type       kp_ff [WHEELS];
   gain_type       ki_ff [WHEELS];
   count_type      count_ff [WHEELS];
   speed_type      speed_w [WHEELS];
   duty_type       fwd_w [WHEELS];
   duty_type       rev_w [WHEELS];

   logic           rsp_valid_ff, rsp_valid_in;
   logic [103:0]   rsp_data_ff;

   logic           csr_wr;
   logic [2:0]     csr_idx;

   // ---------------------------------------------------------------- registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff[0] <= KP_ONE_RST;
         kp_ff[1] <= KP_TWO_RST;
         kp_ff[2] <= KP_THREE_RST;
         kp_ff[3] <= KP_FOUR_RST;
         ki_ff[0] <= KI_ONE_RST;
         ki_ff[1] <= KI_TWO_RST;
         ki_ff[2] <= KI_THREE_RST;
         ki_ff[3] <= KI_FOUR_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_KP_ONE:   kp_ff[0] <= csr_pwdata[GAIN_W-1:0];
            REG_KP_TWO:   kp_ff[1] <= csr_pwdata[GAIN_W-1:0];
            REG_KP_THREE: kp_ff[2] <= csr_pwdata[GAIN_W-1:0];
            REG_KP_FOUR:  kp_ff[3] <= csr_pwdata[GAIN_W-1:0];
            REG_KI_ONE:   ki_ff[0] <= csr_pwdata[GAIN_W-1:0];
            REG_KI_TWO:   ki_ff[1] <= csr_pwdata[GAIN_W-1:0];
            REG_KI_THREE: ki_ff[2] <= csr_pwdata[GAIN_W-1:0];
            REG_KI_FOUR:  ki_ff[3] <= csr_pwdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_KP_ONE:   csr_prdata = {16'd0, kp_ff[0]};
         REG_KP_TWO:   csr_prdata = {16'd0, kp_ff[1]};
         REG_KP_THREE: csr_prdata = {16'd0, kp_ff[2]};
         REG_KP_FOUR:  csr_prdata = {16'd0, kp_ff[3]};
         REG_KI_ONE:   csr_prdata = {16'd0, ki_ff[0]};
         REG_KI_TWO:   csr_prdata = {16'd0, ki_ff[1]};
         REG_KI_THREE: csr_prdata = {16'd0, ki_ff[2]};
         REG_KI_FOUR:  csr_prdata = {16'd0, ki_ff[3]};
         default:      csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- sequencer
   assign req_tready = (phase_ff == PH_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   // commit only when the output register is free or being emptied this cycle
   assign commit     = (phase_ff == PH_COMMIT) & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      case (phase_ff)
         PH_IDLE:   phase_in = req_xfer ? PH_PROD : PH_IDLE;
         PH_PROD:   phase_in = PH_ERR;
         PH_ERR:    phase_in = PH_MUL;
         PH_MUL:    phase_in = PH_STEP;
         PH_STEP:   phase_in = PH_COMMIT;
         PH_COMMIT: phase_in = commit ? PH_IDLE : PH_COMMIT;
         default:   phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   assign ctrl.ld_prod = (phase_ff == PH_PROD);
   assign ctrl.ld_err  = (phase_ff == PH_ERR);
   assign ctrl.ld_mul  = (phase_ff == PH_MUL);
   assign ctrl.ld_step = (phase_ff == PH_STEP);
   assign ctrl.commit  = commit;

   // ---------------------------------------------------------------- capture
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         count_ff[0] <= req_tdata[63:48];
         count_ff[1] <= req_tdata[79:64];
         count_ff[2] <= req_tdata[95:80];
         count_ff[3] <= req_tdata[111:96];
      end
   end

   fwips_mix u_mix (
      .clock       (clock),
      .load        (req_xfer),
      .vel_x       (req_tdata[15:0]),
      .vel_y       (req_tdata[31:16]),
      .vel_rot     (req_tdata[47:32]),
      .speed_one   (speed_w[0]),
      .speed_two   (speed_w[1]),
      .speed_three (speed_w[2]),
      .speed_four  (speed_w[3])
   );

   // ---------------------------------------------------------------- wheel lanes
   for (genvar w = 0; w < WHEELS; w++) begin : g_lane
      fwips_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .speed    (speed_w[w]),
         .count    (count_ff[w]),
         .kp       (kp_ff[w]),
         .ki       (ki_ff[w]),
         .fwd_duty (fwd_w[w]),
         .rev_duty (rev_w[w])
      );
   end

   // ---------------------------------------------------------------- merge / output
   // the four lanes' duties are gathered into one result transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (commit)     rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff <= {rev_w[3], fwd_w[3], rev_w[2], fwd_w[2],
                         rev_w[1], fwd_w[1], rev_w[0], fwd_w[0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
